FILE: design/quaternion_to_euler_angles_defines.svh
// Assertion macros for the quaternion to Euler angles block.
// No dependencies; included by the top level.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define Q2E_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define Q2E_ASSERT(lbl, clk, rst_n, prop, msg)
`define Q2E_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: design/q2e_pkg.sv
// Package for the quaternion to Euler angles block: widths, codes, arctangent table.
// No dependencies.
package q2e_pkg;
    localparam int COMP_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS      = 40;
    localparam int CORDIC_STEPS   = 40;
    localparam int DW             = 62;   // CORDIC datapath width
    localparam int ZW             = 42;   // angle accumulator width

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2,
        POLE_ZERO  = 2'd3
    } pole_t;

    localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

    function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        begin
            p = {64'd0, a} * {64'd0, b};
            return p[127:64];
        end
    endfunction

    // atan(2^-i) in units of 2^-40 turn; evaluated at elaboration only
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic [63:0] sum;
        logic [63:0] turns;
        int e;
        begin
            sum = 64'd0;
            if (i == 0)
                return ZW'(64'd1 << (FRAC_BITS - 3));
            for (int k = 0; k < 32; k++)
            begin
                e = i * (2 * k + 1);
                if (e < 64)
                begin
                    if (k % 2 == 1)
                        sum = sum - ((64'd1 << (64 - e)) / 64'(2 * k + 1));
                    else
                        sum = sum + ((64'd1 << (64 - e)) / 64'(2 * k + 1));
                end
            end
            turns = mul_hi(sum, INV_TWO_PI);
            return ZW'((turns + (64'd1 << 23)) >> 24);
        end
    endfunction
endpackage

FILE: design/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angles block (heading, attitude, bank).
// Depends on q2e_pkg, q2e_cordic and quaternion_to_euler_angles_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one quaternion word comp_w..comp_z,
//   signed, unnormalized. Output channel (out_valid/out_ready) carries heading,
//   attitude, bank as binary angles plus pole_code.
//   Throughput: one word per cycle. The pipeline moves as one: every stage
//   advances whenever the output register is empty or being taken.
//   Latency: 87 register stages: 3 product/normalize stages, a first CORDIC
//   pass of 41 stages (heading, bank and both attitude magnitudes side by side),
//   one normalize stage, a second 41-stage pass for the attitude arctangent,
//   and the output register.
//   The CORDIC pipelines (one step per stage) set the latency.
//   Reset clears all valid bits; payload registers are not reset.
//   When the receiver stalls, the whole pipeline holds; nothing is dropped.
`include "quaternion_to_euler_angles_defines.svh"
module quaternion_to_euler_angles
    import q2e_pkg::*;
#(
    parameter int COMP_BITS  = COMP_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COMP_BITS-1:0]  comp_w,
    input  logic signed [COMP_BITS-1:0]  comp_x,
    input  logic signed [COMP_BITS-1:0]  comp_y,
    input  logic signed [COMP_BITS-1:0]  comp_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ANGLE_BITS-1:0] heading_angle,
    output logic signed [ANGLE_BITS-1:0] attitude_angle,
    output logic signed [ANGLE_BITS-1:0] bank_angle,
    output logic [1:0]                   pole_code
);
    localparam int CW = (COMP_BITS > 31) ? 31 : COMP_BITS;
    localparam int RSH = FRAC_BITS - ANGLE_BITS;
    localparam int SBW = 2;

    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // stage 1: trim components and square/cross products
    logic signed [CW-1:0] w1_reg, x1_reg, y1_reg, z1_reg;
    logic                 v1_reg;
    logic signed [63:0]   sw_reg, sx_reg, sy_reg, sz_reg;
    logic signed [63:0]   xy_reg, zw_reg, yw_reg, xz_reg, xw_reg, yz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    logic signed [CW-1:0] w0, x0, y0, z0;
    assign w0 = CW'(comp_w >>> (COMP_BITS - CW));
    assign x0 = CW'(comp_x >>> (COMP_BITS - CW));
    assign y0 = CW'(comp_y >>> (COMP_BITS - CW));
    assign z0 = CW'(comp_z >>> (COMP_BITS - CW));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= w0; x1_reg <= x0; y1_reg <= y0; z1_reg <= z0;
            sw_reg <= 64'(w0) * 64'(w0);
            sx_reg <= 64'(x0) * 64'(x0);
            sy_reg <= 64'(y0) * 64'(y0);
            sz_reg <= 64'(z0) * 64'(z0);
            xy_reg <= 64'(x0) * 64'(y0);
            zw_reg <= 64'(z0) * 64'(w0);
            yw_reg <= 64'(y0) * 64'(w0);
            xz_reg <= 64'(x0) * 64'(z0);
            xw_reg <= 64'(x0) * 64'(w0);
            yz_reg <= 64'(y0) * 64'(z0);
        end
    end

    // stage 2: sums, pole tests
    logic                 v2_reg;
    logic [1:0]           pole2_reg;
    logic signed [63:0]   a2_reg, b2_reg, c2_reg, d2_reg, p2_reg;
    logic signed [CW-1:0] w2_reg, x2_reg;
    logic [63:0]          unit1;
    logic signed [63:0]   test1;
    logic [73:0]          lhs1, rhs1;

    assign unit1 = sw_reg + sx_reg + sy_reg + sz_reg;
    assign test1 = xy_reg + zw_reg;
    assign lhs1  = 74'((test1 < 0) ? -test1 : test1) * 74'd1000;
    assign rhs1  = 74'(unit1) * 74'd499;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (unit1 == 64'd0)
                pole2_reg <= POLE_ZERO;
            else if (test1 > 0 && lhs1 > rhs1)
                pole2_reg <= POLE_NORTH;
            else if (test1 < 0 && lhs1 > rhs1)
                pole2_reg <= POLE_SOUTH;
            else
                pole2_reg <= POLE_NONE;
            a2_reg <= (sx_reg + sw_reg) - (sy_reg + sz_reg);
            b2_reg <= (yw_reg - xz_reg) <<< 1;
            c2_reg <= (xw_reg - yz_reg) <<< 1;
            d2_reg <= (sy_reg + sw_reg) - (sx_reg + sz_reg);
            p2_reg <= test1 <<< 1;
            w2_reg <= w1_reg;
            x2_reg <= x1_reg;
        end
    end

    // stage 3: pick operands and normalize into [2^57, 2^58)
    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [7:0] nshift(input logic [63:0] m);
        logic signed [7:0] s;
        begin
            s = 8'sd0;
            for (int k = 0; k < 64; k++)
                if (m[k])
                    s = 8'(k - 57);
            return s;
        end
    endfunction

    function automatic logic signed [DW-1:0] app(input logic signed [63:0] v,
                                                 input logic signed [7:0] s);
        logic signed [63:0] r;
        begin
            if (s >= 0)
                r = v >>> s;
            else
                r = v <<< (-s);
            return DW'(r);
        end
    endfunction

    logic [63:0]        m_h, m_b, m_t;
    logic signed [63:0] hx, hy;
    logic signed [7:0]  s_h, s_b, s_t;
    logic               pole_side;

    assign pole_side = (pole2_reg == POLE_NORTH) || (pole2_reg == POLE_SOUTH);
    assign hx = pole_side ? 64'(w2_reg) : a2_reg;
    assign hy = pole_side ? 64'(x2_reg) : b2_reg;
    assign m_h = (mag(hx) > mag(hy)) ? mag(hx) : mag(hy);
    assign m_b = (mag(d2_reg) > mag(c2_reg)) ? mag(d2_reg) : mag(c2_reg);
    assign m_t = (mag(p2_reg) > m_h) ? mag(p2_reg) : m_h;
    assign s_h = nshift(m_h);
    assign s_b = nshift(m_b);
    assign s_t = nshift(m_t);

    logic                 v3_reg;
    logic [1:0]           pole3_reg;
    logic                 hz3_reg, bz3_reg, pn3_reg;
    logic signed [DW-1:0] hx3_reg, hy3_reg, bx3_reg, by3_reg;
    logic signed [DW-1:0] ax3_reg, ay3_reg, px3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pole3_reg <= pole2_reg;
            hz3_reg <= (m_h == 64'd0);
            bz3_reg <= (m_b == 64'd0);
            pn3_reg <= (p2_reg < 0);
            hx3_reg <= app(hx, s_h);
            hy3_reg <= app(hy, s_h);
            bx3_reg <= app(d2_reg, s_b);
            by3_reg <= app(c2_reg, s_b);
            ax3_reg <= app(a2_reg, s_t);
            ay3_reg <= app(b2_reg, s_t);
            px3_reg <= app(64'(mag(p2_reg)), s_t);
        end
    end

    // first CORDIC pass: heading, bank, attitude magnitudes
    localparam int SB1 = 2 + 3;
    logic                 vh, vb, va, vp;
    logic signed [ZW-1:0] zh, zb, za_unused, zp_unused;
    logic signed [DW-1:0] mh_unused, mb_unused, ka, kp;
    logic [SB1-1:0]       sbh;
    logic [0:0]           sbb, sba, sbp;

    q2e_cordic #(.SB(SB1)) u_head (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg),
        .in_x(hx3_reg), .in_y(hy3_reg),
        .in_sb({pole3_reg, hz3_reg, bz3_reg, pn3_reg}),
        .out_valid(vh), .out_z(zh), .out_mag(mh_unused), .out_sb(sbh));
    q2e_cordic #(.SB(1)) u_bank (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg),
        .in_x(bx3_reg), .in_y(by3_reg), .in_sb(1'b0),
        .out_valid(vb), .out_z(zb), .out_mag(mb_unused), .out_sb(sbb));
    q2e_cordic #(.SB(1)) u_amag (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg),
        .in_x(ax3_reg), .in_y(ay3_reg), .in_sb(1'b0),
        .out_valid(va), .out_z(za_unused), .out_mag(ka), .out_sb(sba));
    q2e_cordic #(.SB(1)) u_pmag (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg),
        .in_x(px3_reg), .in_y('0), .in_sb(1'b0),
        .out_valid(vp), .out_z(zp_unused), .out_mag(kp), .out_sb(sbp));

    // stage between passes: normalize attitude operands
    logic [1:0]         pole4;
    logic               hz4, bz4, pn4;
    logic [63:0]        m_k;
    logic signed [7:0]  s_k;
    assign {pole4, hz4, bz4, pn4} = sbh;
    assign m_k = (mag(64'(ka)) > mag(64'(kp))) ? mag(64'(ka)) : mag(64'(kp));
    assign s_k = nshift(m_k);

    logic                 v5_reg;
    logic [1:0]           pole5_reg;
    logic                 pn5_reg, kz5_reg;
    logic signed [ZW-1:0] zh5_reg, zb5_reg;
    logic signed [DW-1:0] kx5_reg, ky5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= vh;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pole5_reg <= pole4;
            pn5_reg   <= pn4;
            kz5_reg   <= (m_k == 64'd0);
            zh5_reg   <= hz4 ? '0 : zh;
            zb5_reg   <= bz4 ? '0 : zb;
            kx5_reg   <= app(64'(ka), s_k);
            ky5_reg   <= app(64'(kp), s_k);
        end
    end

    // second CORDIC pass: attitude arctangent
    localparam int SB2 = 2 + 1 + 1 + 2 * ZW;
    logic                 v6;
    logic signed [ZW-1:0] zt;
    logic signed [DW-1:0] mt_unused;
    logic [SB2-1:0]       sb6;
    q2e_cordic #(.SB(SB2)) u_att (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .in_x(kx5_reg), .in_y(ky5_reg),
        .in_sb({pole5_reg, pn5_reg, kz5_reg, zh5_reg, zb5_reg}),
        .out_valid(v6), .out_z(zt), .out_mag(mt_unused), .out_sb(sb6));

    logic [1:0]           pole6;
    logic                 pn6, kz6;
    logic signed [ZW-1:0] zh6, zb6, zt6;
    logic signed [ZW+1:0] hsel;
    assign {pole6, pn6, kz6, zh6, zb6} = sb6;
    assign zt6 = kz6 ? '0 : (pn6 ? -zt : zt);

    function automatic logic [ANGLE_BITS-1:0] to_ang(input logic signed [ZW+1:0] v);
        logic signed [ZW+1:0] r;
        begin
            r = (v + (ZW+2)'(64'd1 << (RSH - 1))) >>> RSH;
            return r[ANGLE_BITS-1:0];
        end
    endfunction

    always_comb
    begin
        case (pole6)
            POLE_NORTH: hsel = (ZW+2)'(zh6) <<< 1;
            POLE_SOUTH: hsel = -((ZW+2)'(zh6) <<< 1);
            default:    hsel = (ZW+2)'(zh6);
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= v6;
    end

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pole_code <= pole6;
            case (pole6)
                POLE_ZERO:
                begin
                    heading_angle  <= '0;
                    attitude_angle <= '0;
                    bank_angle     <= '0;
                end
                POLE_NORTH:
                begin
                    heading_angle  <= to_ang(hsel);
                    attitude_angle <= QUARTER;
                    bank_angle     <= '0;
                end
                POLE_SOUTH:
                begin
                    heading_angle  <= to_ang(hsel);
                    attitude_angle <= -QUARTER;
                    bank_angle     <= '0;
                end
                default:
                begin
                    heading_angle  <= to_ang(hsel);
                    attitude_angle <= to_ang((ZW+2)'(zt6));
                    bank_angle     <= to_ang((ZW+2)'(zb6));
                end
            endcase
        end
    end

    // lanes of the first pass advance together
    `Q2E_ASSERT(a_lanes_aligned, clk, rst_n, (vh == vb) && (vh == va) && (vh == vp), "CORDIC lanes out of step")
    // a held result stays put while the receiver stalls
    `Q2E_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(heading_angle)), "result changed while stalled")
    // pole results carry zero bank
    `Q2E_ASSERT(a_pole_bank, clk, rst_n, (out_valid && (pole_code != POLE_NONE)) |-> (bank_angle == '0), "pole result with nonzero bank")
endmodule

FILE: design/q2e_cordic.sv
// Pipelined vectoring CORDIC, one step per register stage, with side-band payload.
// Depends on q2e_pkg.
module q2e_cordic
    import q2e_pkg::*;
#(
    parameter int SB = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [DW-1:0]  in_x,
    input  logic signed [DW-1:0]  in_y,
    input  logic [SB-1:0]         in_sb,
    output logic                  out_valid,
    output logic signed [ZW-1:0]  out_z,
    output logic signed [DW-1:0]  out_mag,
    output logic [SB-1:0]         out_sb
);
    localparam int N = CORDIC_STEPS + 1;
    localparam logic signed [ZW-1:0] HALF = ZW'(64'd1 << (FRAC_BITS - 1));

    logic signed [DW-1:0] x_reg [N];
    logic signed [DW-1:0] y_reg [N];
    logic signed [ZW-1:0] z_reg [N];
    logic [SB-1:0]        sb_reg [N];
    logic [N-1:0]         v_reg;

    // stage 0: fold into the right half plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= in_sb;
            if (in_x < 0)
            begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                z_reg[0] <= (in_y < 0) ? -HALF : HALF;
            end
            else
            begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] T = atan_step(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[i+1] <= sb_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + T;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - T;
                end
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_z     = z_reg[N-1];
    assign out_mag   = x_reg[N-1];
    assign out_sb    = sb_reg[N-1];
endmodule

FILE: tb/sv/tb_quaternion_to_euler_angles.sv
// Self-checking testbench for quaternion_to_euler_angles: drives quaternion words and checks
// heading, attitude, bank and pole code bit for bit against a CORDIC predictor.
// Depends on q2e_pkg and the quaternion_to_euler_angles RTL.
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles;
    import q2e_pkg::*;

    localparam int CB = 16;
    localparam int AB = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 750;

    // Expected output word of the block
    typedef struct {
        logic signed [AB-1:0] heading;
        logic signed [AB-1:0] attitude;
        logic signed [AB-1:0] bank;
        pole_t                pole;
    } euler_t;

    // Scoreboard: computes the Euler angles of each accepted quaternion and
    // checks output words in order against them.
    class euler_scoreboard;
        euler_t pending[$];
        longint arc_step[40];
        int     errors;
        int     checked;
        int     pole_hits[4];

        function new();
            logic [63:0]  sum;
            logic [127:0] prod;
            int           e;
            errors = 0;
            checked = 0;
            foreach (pole_hits[i]) pole_hits[i] = 0;
            arc_step[0] = 64'sd1 <<< 37;
            for (int i = 1; i < 40; i++)
            begin
                sum = 64'd0;
                for (int k = 0; k < 32; k++)
                begin
                    e = i * (2 * k + 1);
                    if (e < 64)
                    begin
                        if (k % 2 == 1)
                            sum = sum - ((64'd1 << (64 - e)) / 64'(2 * k + 1));
                        else
                            sum = sum + ((64'd1 << (64 - e)) / 64'(2 * k + 1));
                    end
                end
                prod = {64'd0, sum} * {64'd0, 64'h28BE60DB9391054A};
                arc_step[i] = longint'((prod[127:64] + (64'd1 << 23)) >> 24);
            end
        endfunction

        function longint unsigned magn(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // shift that brings m into [2^57, 2^58); positive means right
        function int scale_shift(longint unsigned m);
            int sh;
            sh = 0;
            if (m == 0)
                return 0;
            while (m >= (64'd1 << 58)) begin m = m >> 1; sh++; end
            while (m < (64'd1 << 57)) begin m = m << 1; sh--; end
            return sh;
        endfunction

        function longint rescale(longint v, int sh);
            return (sh >= 0) ? (v >>> sh) : (v <<< (-sh));
        endfunction

        // vectoring rotation; returns angle in 2^-40 turn, gain*|v| in mag
        function longint rotate(longint x, longint y, output longint mag);
            longint z;
            longint dx;
            longint dy;
            z = 0;
            if (x < 0)
            begin
                z = (y < 0) ? -(64'sd1 <<< 39) : (64'sd1 <<< 39);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 40; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin x += dx; y -= dy; z += arc_step[i]; end
                else       begin x -= dx; y += dy; z -= arc_step[i]; end
            end
            mag = x;
            return z;
        endfunction

        function longint arctan2(longint y, longint x);
            longint unsigned m;
            longint          junk;
            int              sh;
            m = (magn(x) > magn(y)) ? magn(x) : magn(y);
            if (m == 0)
                return 0;
            sh = scale_shift(m);
            return rotate(rescale(x, sh), rescale(y, sh), junk);
        endfunction

        function logic [AB-1:0] quantize(longint v);
            longint r;
            r = (v + (64'sd1 <<< 23)) >>> 24;
            return r[AB-1:0];
        endfunction

        function euler_t convert(longint w, longint x, longint y, longint z);
            euler_t          r;
            longint          sw, sx, sy, sz, unit, tst, a, b, c, d, p, ka, kp, junk, t;
            longint unsigned m;
            int              sh;
            sw = w * w; sx = x * x; sy = y * y; sz = z * z;
            unit = sw + sx + sy + sz;
            tst = x * y + z * w;
            r.heading = '0; r.attitude = '0; r.bank = '0; r.pole = POLE_NONE;
            if (unit == 0)
            begin
                r.pole = POLE_ZERO;
                return r;
            end
            if (tst > 0 && 1000 * tst > 499 * unit)
            begin
                r.heading = quantize(2 * arctan2(x, w));
                r.attitude = AB'(1 <<< (AB - 2));
                r.pole = POLE_NORTH;
                return r;
            end
            if (tst < 0 && -1000 * tst > 499 * unit)
            begin
                r.heading = quantize(-2 * arctan2(x, w));
                r.attitude = AB'(-(1 <<< (AB - 2)));
                r.pole = POLE_SOUTH;
                return r;
            end
            a = (sx + sw) - (sy + sz);
            b = 2 * (y * w - x * z);
            c = 2 * (x * w - y * z);
            d = (sy + sw) - (sx + sz);
            p = 2 * tst;
            r.heading = quantize(arctan2(b, a));
            r.bank = quantize(arctan2(c, d));
            // attitude from the two magnitudes at one common scale
            m = magn(a);
            if (magn(b) > m) m = magn(b);
            if (magn(p) > m) m = magn(p);
            sh = scale_shift(m);
            junk = rotate(rescale(a, sh), rescale(b, sh), ka);
            junk = rotate(rescale(longint'(magn(p)), sh), 0, kp);
            t = arctan2(kp, ka);
            r.attitude = quantize(p < 0 ? -t : t);
            return r;
        endfunction

        function void note_input(logic signed [CB-1:0] w, logic signed [CB-1:0] x,
                                 logic signed [CB-1:0] y, logic signed [CB-1:0] z);
            pending.push_back(convert(w, x, y, z));
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        endtask

        task check_result(logic signed [AB-1:0] h, logic signed [AB-1:0] a,
                          logic signed [AB-1:0] b, logic [1:0] pc);
            euler_t e;
            if (pending.size() == 0)
            begin
                report("unexpected word, pole_code", pc, -1);
                return;
            end
            e = pending.pop_front();
            checked++;
            pole_hits[e.pole]++;
            if (h !== e.heading) report("heading_angle", h, e.heading);
            if (a !== e.attitude) report("attitude_angle", a, e.attitude);
            if (b !== e.bank) report("bank_angle", b, e.bank);
            if (pc !== e.pole) report("pole_code", pc, e.pole);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CB-1:0] comp_w, comp_x, comp_y, comp_z;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [AB-1:0] heading_angle, attitude_angle, bank_angle;
    logic [1:0]           pole_code;

    euler_scoreboard sb;
    bit  steady;        // no idling on either side while set
    bit  rx_hold;       // receiver holds off while set
    bit  start_hold;    // asks the hold-off process to begin
    int  cycles;
    int  sent;

    quaternion_to_euler_angles uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .comp_w(comp_w), .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .heading_angle(heading_angle), .attitude_angle(attitude_angle),
        .bank_angle(bank_angle), .pole_code(pole_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one quaternion word; inputs move only on the falling edge, so
    // hold valid and payload until the rising edge that takes the word.
    // Components are taken as integers and trimmed to the port width.
    task send_word(input int w, input int x, input int y, input int z);
        while (!steady && $urandom_range(99) < 23)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        comp_w = CB'(w); comp_x = CB'(x); comp_y = CB'(y); comp_z = CB'(z);
        do @(posedge clk); while (!in_ready);
        sb.note_input(CB'(w), CB'(x), CB'(y), CB'(z));
        sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Random word: mostly full range, some small values, and many near a pole
    task send_random();
        int q[4];
        int kind;
        int mag;
        int n;
        kind = $urandom_range(9);
        if (kind < 5)
        begin
            foreach (q[i]) q[i] = int'($urandom_range(65535)) - 32768;
        end
        else if (kind < 7)
        begin
            foreach (q[i]) q[i] = int'($urandom_range(15)) - 8;
        end
        else
        begin
            // x*y + z*w close to half of the norm: x=y, z=w (north) or x=-y, z=-w
            mag = $urandom_range(16383, 1);
            n = $urandom_range(mag / 16 + 2);
            q[0] = int'($urandom_range(mag));
            q[1] = int'($urandom_range(mag));
            q[2] = q[1] + int'($urandom_range(2 * n)) - n;
            q[3] = q[0] + int'($urandom_range(2 * n)) - n;
            if ($urandom_range(1)) begin q[2] = -q[2]; q[3] = -q[3]; end
            if ($urandom_range(1)) begin q[0] = -q[0]; q[2] = -q[2]; end
        end
        send_word(q[0], q[1], q[2], q[3]);
    endtask

    // Receiver: ready changes on the falling edge only
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = !rx_hold && (steady || $urandom_range(99) >= 23);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(heading_angle, attitude_angle, bank_angle, pole_code);
    end

    // Long receiver hold-off, counted here, so the pipeline fills and stalls input
    initial
    begin
        rx_hold = 1'b0;
        wait (start_hold);
        @(negedge clk);
        rx_hold = 1'b1;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** quaternion_to_euler_angles: FAILED **");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        cycles = 0;
        sent = 0;
        steady = 1'b0;
        start_hold = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        comp_w = '0; comp_x = '0; comp_y = '0; comp_z = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero quaternion, axes, extremes, exact poles, half-turn heading
        send_word(0, 0, 0, 0);
        send_word(16384, 0, 0, 0);
        send_word(-32768, 0, 0, 0);
        send_word(0, 32767, 0, 0);
        send_word(0, 0, 32767, 0);
        send_word(0, 0, 0, 32767);
        send_word(0, -32768, 0, 0);
        send_word(-32768, -32768, -32768, -32768);
        send_word(32767, 32767, 32767, 32767);
        send_word(32767, -32768, 32767, -32768);
        send_word(10000, 10000, -10000, -10000);
        send_word(0, 1, 1, 0);
        send_word(0, 1, -1, 0);
        send_word(1000, 1000, 1000, 998);
        send_word(1000, 1000, 1000, 996);
        send_word(-1000, 1000, -1000, 1000);
        send_word(0, 0, 32767, -32768);
        send_word(0, 0, 0, 1);
        send_word(-1, 0, 0, 0);
        send_word(1, -1, 0, 0);
        send_word(12345, -23456, 4321, -321);
        send_word(-32768, 32767, 0, 0);

        // Pause the sender until every pending word has come back
        while (sb.pending.size() != 0) @(posedge clk);
        @(negedge clk);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 100) start_hold = 1'b1;
            steady = (i >= 400 && i < 550);
            send_random();
        end
        steady = 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report("words never returned", sb.pending.size(), 0);

        $display("covered %0d quaternion words: %0d regular, %0d north, %0d south, %0d zero",
                 sent, sb.pole_hits[POLE_NONE], sb.pole_hits[POLE_NORTH],
                 sb.pole_hits[POLE_SOUTH], sb.pole_hits[POLE_ZERO]);
        $display("with random gaps and stalls, a long receiver hold-off and a drained pause");
        if (sb.errors == 0)
            $display("** quaternion_to_euler_angles: PASSED **");
        else
            $display("** quaternion_to_euler_angles: FAILED **");
        $finish;
    end
endmodule
